@@ rtl/hra_pkg.sv @@
// ----------------------------------------------------------------------------
// hra_pkg
// Shared types and constants of the handle range allocator.
// ----------------------------------------------------------------------------
package hra_pkg;

  localparam longint unsigned MaxHandles = 64'd65535;
  localparam int unsigned RangeDepth = 1024;
  localparam int unsigned IdxW = $clog2(RangeDepth);
  localparam int unsigned CntW = $clog2(RangeDepth + 1);
  localparam int unsigned HandleW = 16;

  // handle space never grows past the smaller of MaxHandles and the field range
  localparam logic [HandleW-1:0] LimitHandles =
    (MaxHandles < 64'd65535) ? HandleW'(MaxHandles) : HandleW'(65535);

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StFull     = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic [HandleW-1:0] first;
    logic [HandleW-1:0] last;
  } range_t;

  typedef struct packed {
    logic            we;
    logic [IdxW-1:0] waddr;
    range_t          wdata;
    logic            re;
    logic [IdxW-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/handle_range_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// handle_range_allocator_unit
// Handle allocator keeping free handles as a stack of inclusive ranges.
// ----------------------------------------------------------------------------
// Result: strobed in the cycle after the request transfer.
// Throughput: one request per cycle; an allocate that pops a range with more
//   ranges left below it raises busy while the new top range is read back
//   from the stack memory.
// Reset: asynchronous, active low; clears stack count, capacity and strobes.
//   Stack memory has no reset. Results cannot be stalled by the receiver.
module handle_range_allocator_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        cmd_i,
  input  logic [hra_pkg::HandleW-1:0] handle_in_i,
  output logic                        valid_o,
  output logic [hra_pkg::HandleW-1:0] handle_out_o,
  output logic [1:0]                  status_o
);
  import hra_pkg::*;

  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [HandleW-1:0] cap_q, cap_d;
  range_t             top_q, top_d;
  logic               load_q, load_d;
  logic               valid_q, valid_d;
  logic [HandleW-1:0] handle_q, handle_d;
  status_e            status_q, status_d;

  mem_req_t           mem_req;
  range_t             mem_rdata;

  logic               accept;
  logic [HandleW:0]   cap_grow;
  logic [HandleW-1:0] new_cap;
  logic [HandleW-1:0] grow_first;
  logic [CntW-1:0]    cnt_m1;
  logic [CntW-1:0]    cnt_m2;

  assign accept     = start & ~busy;
  assign cap_grow   = {cap_q, 1'b1};
  assign new_cap    = (cap_grow > {1'b0, LimitHandles}) ? LimitHandles : cap_grow[HandleW-1:0];
  assign grow_first = cap_q + HandleW'(1);
  assign cnt_m1     = cnt_q - CntW'(1);
  assign cnt_m2     = cnt_q - CntW'(2);

  always_comb begin
    cnt_d     = cnt_q;
    cap_d     = cap_q;
    top_d     = top_q;
    load_d    = 1'b0;
    valid_d   = 1'b0;
    handle_d  = '0;
    status_d  = StOk;
    mem_req   = '0;

    if (load_q) begin
      top_d = mem_rdata;
    end

    if (accept) begin
      valid_d = 1'b1;
      if (cmd_i == CmdAlloc) begin
        if (cnt_q == '0) begin
          if (cap_q >= LimitHandles) begin
            status_d = StFull;
          end else begin
            // grow, take the new range's first handle and push the rest, if any, in one go
            cap_d    = new_cap;
            handle_d = grow_first;
            if (grow_first < new_cap) begin
              top_d.first = grow_first + HandleW'(1);
              top_d.last  = new_cap;
              cnt_d       = CntW'(1);
            end
          end
        end else begin
          handle_d = top_q.first;
          if (top_q.first >= top_q.last) begin
            cnt_d = cnt_m1;
            if (cnt_q > CntW'(1)) begin
              // refill cached top from memory next cycle
              mem_req.re    = 1'b1;
              mem_req.raddr = cnt_m2[IdxW-1:0];
              load_d        = 1'b1;
            end
          end else begin
            top_d.first = top_q.first + HandleW'(1);
          end
        end
      end else begin
        if ((handle_in_i != '0) && (handle_in_i <= cap_q)) begin
          if (cnt_q == CntW'(RangeDepth)) begin
            status_d = StOverflow;
          end else begin
            if (cnt_q != '0) begin
              mem_req.we    = 1'b1;
              mem_req.waddr = cnt_m1[IdxW-1:0];
              mem_req.wdata = top_q;
            end
            top_d.first = handle_in_i;
            top_d.last  = handle_in_i;
            cnt_d       = cnt_q + CntW'(1);
          end
        end
      end
    end
  end

  hra_stack_mem u_stack_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      cap_q   <= '0;
      load_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      cnt_q   <= cnt_d;
      cap_q   <= cap_d;
      load_q  <= load_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q    <= top_d;
    handle_q <= handle_d;
    status_q <= status_d;
  end

  assign busy         = load_q;
  assign valid_o      = valid_q;
  assign handle_out_o = handle_q;
  assign status_o     = status_q;

endmodule

@@ rtl/hra_stack_mem.sv @@
// ----------------------------------------------------------------------------
// hra_stack_mem
// Range stack storage below the cached top entry: one write, one registered read.
// ----------------------------------------------------------------------------
module hra_stack_mem (
  input  logic              clk_i,
  input  hra_pkg::mem_req_t req_i,
  output hra_pkg::range_t   rdata_o
);
  import hra_pkg::*;

  range_t mem_q [RangeDepth];
  range_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sim/handle_range_allocator_unit_test.sv @@
// ----------------------------------------------------------------------------
// handle_range_allocator_unit_test
// Self-checking bench for the handle range allocator. A scoreboard class keeps
// its own free-range stack and handle capacity, predicts the grant and status
// of every accepted request, and checks each strobed result in order. Traffic
// runs in bursts with random gaps: directed requests first, then random
// allocate/free mixes and a stack overflow run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module handle_range_allocator_unit_test;
  import hra_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomItems = 450;

  typedef struct {
    logic [HandleW-1:0] handle;
    status_e            code;
  } grant_t;

  class free_range_model;
    logic [HandleW-1:0] first_h [RangeDepth];
    logic [HandleW-1:0] last_h [RangeDepth];
    int unsigned        depth;
    logic [HandleW-1:0] capacity;
    grant_t             pending [$];
    int unsigned        errors;

    function new();
      depth = 0;
      capacity = '0;
      errors = 0;
    endfunction

    // predict the outcome of one accepted request and advance the stack
    function void note_request(logic cmd, logic [HandleW-1:0] h);
      grant_t             g;
      logic [HandleW:0]   grown;
      bit                 ready;
      g.handle = '0;
      g.code = StOk;
      if (cmd == CmdAlloc) begin
        ready = 1'b1;
        if (depth == 0) begin
          if (capacity >= LimitHandles) begin
            ready = 1'b0;
            g.code = StFull;
          end else begin
            grown = {capacity, 1'b1};
            if (grown > {1'b0, LimitHandles}) grown = {1'b0, LimitHandles};
            first_h[0] = capacity + 1'b1;
            last_h[0] = grown[HandleW-1:0];
            capacity = grown[HandleW-1:0];
            depth = 1;
          end
        end
        if (ready && depth > 0) begin
          g.handle = first_h[depth-1];
          if (first_h[depth-1] >= last_h[depth-1]) depth--;
          else first_h[depth-1] = first_h[depth-1] + 1'b1;
        end
      end else if (h != '0 && h <= capacity) begin
        if (depth >= RangeDepth) begin
          g.code = StOverflow;
        end else begin
          first_h[depth] = h;
          last_h[depth] = h;
          depth++;
        end
      end
      pending.push_back(g);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_grant(logic [HandleW-1:0] h, logic [1:0] st);
      grant_t want;
      if (pending.size() == 0) begin
        report("result strobe with no request outstanding");
        return;
      end
      want = pending.pop_front();
      if (h !== want.handle)
        report($sformatf("handle_out %0d, predicted %0d", h, want.handle));
      if (st !== want.code)
        report($sformatf("status %0d, predicted %0d", st, want.code));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cmd_i;
  logic [HandleW-1:0] handle_in_i;
  logic               valid_o;
  logic [HandleW-1:0] handle_out_o;
  logic [1:0]         status_o;

  free_range_model ledger = new();
  int unsigned     burst_left;
  int unsigned     stall_cycles;

  handle_range_allocator_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .cmd_i        (cmd_i),
    .handle_in_i  (handle_in_i),
    .valid_o      (valid_o),
    .handle_out_o (handle_out_o),
    .status_o     (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // results cannot be held off, so every strobe is checked on the edge ending it
  always @(posedge clk_i) begin
    if (rst_ni && valid_o === 1'b1) ledger.check_grant(handle_out_o, status_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // one request transfer; start stays high into the next request of a burst
  task send(logic cmd, logic [HandleW-1:0] h);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    start <= 1'b1;
    cmd_i <= cmd;
    handle_in_i <= h;
    do @(posedge clk_i); while (busy);
    ledger.note_request(cmd, h);
    burst_left--;
  endtask

  task drain();
    start <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (ledger.pending.size() != 0) @(posedge clk_i);
  endtask

  task random_traffic(int unsigned count);
    int unsigned sel;
    int unsigned cap;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      cap = ledger.capacity;
      if (sel < 55) send(CmdAlloc, HandleW'($urandom));
      else if (sel < 92) send(CmdFree, (cap == 0) ? '0 : HandleW'($urandom_range(1, cap)));
      else if (sel < 96) send(CmdFree, '0);
      else if (cap < 65535) send(CmdFree, HandleW'($urandom_range(cap + 1, 65535)));
      else send(CmdFree, '0);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    cmd_i = CmdAlloc;
    handle_in_i = '0;
    burst_left = 0;
    stall_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: invalid frees on an empty space, growth, pops with reuse
    send(CmdFree, '0);
    send(CmdFree, 16'hFFFF);
    send(CmdAlloc, 16'hFFFF);
    send(CmdAlloc, '0);
    send(CmdFree, 16'd1);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdFree, 16'd7);
    send(CmdFree, 16'd8);
    send(CmdFree, '0);
    send(CmdFree, 16'd2);
    send(CmdFree, 16'd3);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdAlloc, '0);
    send(CmdFree, 16'h8000);
    send(CmdAlloc, 16'h5555);

    random_traffic(RandomItems);

    // fill the range stack with single-handle ranges, then push past the top
    drain();
    while (ledger.depth < RangeDepth)
      send(CmdFree, HandleW'($urandom_range(1, ledger.capacity)));
    repeat (4) send(CmdFree, HandleW'($urandom_range(1, ledger.capacity)));
    repeat (40) send(CmdAlloc, HandleW'($urandom));
    random_traffic(60);

    drain();
    repeat (10) @(posedge clk_i);
    if (ledger.pending.size() != 0)
      ledger.report($sformatf("%0d results never arrived", ledger.pending.size()));
    if (ledger.errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hra_pkg.sv
rtl/hra_stack_mem.sv
rtl/handle_range_allocator_unit.sv
sim/handle_range_allocator_unit_test.sv
